>>> rtl/core/rrw_pkg.sv
// Shared types, constants and helper functions for the record ring.
package rrw_pkg;

    localparam int RING_BYTES = 16384;
    localparam int HDR_BYTES  = 8;
    localparam int MIN_RING   = 64;
    localparam int HDR_SLOTS  = RING_BYTES / HDR_BYTES;
    localparam int MARGIN     = 2 * HDR_BYTES;

    localparam int LEN_W     = 15;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int OFF_W     = $clog2(RING_BYTES);
    localparam int SLOT_W    = $clog2(HDR_SLOTS);
    localparam int HDR_SHIFT = $clog2(HDR_BYTES);
    localparam int SUM_W     = OFF_W + 2;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        byte_t           data_byte;
        len_t            request_length;
    } cmd_t;

    typedef struct packed {
        len_t  accepted_length;
        logic  blocked;
        byte_t read_byte_out;
        logic  byte_valid;
        logic  last_of_record;
        logic  wake_writer;
    } res_t;

    // x is below twice the ring size, so one conditional subtract wraps it
    function automatic off_t wrap_off(input sum_t x, input len_t size);
        sum_t d;
        d = x - SUM_W'(size);
        return (x >= SUM_W'(size)) ? d[OFF_W-1:0] : x[OFF_W-1:0];
    endfunction

    function automatic sum_t round_hdr(input sum_t x);
        sum_t t;
        t = x + SUM_W'(HDR_BYTES - 1);
        return t & ~SUM_W'(HDR_BYTES - 1);
    endfunction

    function automatic slot_t slot_of(input off_t off);
        return off[OFF_W-1:HDR_SHIFT];
    endfunction

    // clamp to [MIN_RING, RING_BYTES], then round up to a header multiple
    function automatic len_t ring_size_of(input len_t v);
        sum_t t;
        t = round_hdr(SUM_W'(v));
        if (v < LEN_W'(MIN_RING))
            return LEN_W'(MIN_RING);
        else if (v > LEN_W'(RING_BYTES))
            return LEN_W'(RING_BYTES);
        else
            return t[LEN_W-1:0];
    endfunction

endpackage

>>> rtl/core/rrw_if.sv
// Request, result and configuration channel interfaces.
interface rrw_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [rrw_pkg::OP_W-1:0]  opcode;
    rrw_pkg::byte_t            data_byte;
    rrw_pkg::len_t             request_length;

    modport source (output valid, output opcode, output data_byte, output request_length,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input request_length,
                    output ready);
endinterface

interface rrw_rsp_if;
    logic           valid;
    logic           ready;
    rrw_pkg::len_t  accepted_length;
    logic           blocked;
    rrw_pkg::byte_t read_byte_out;
    logic           byte_valid;
    logic           last_of_record;
    logic           wake_writer;

    modport source (output valid, output accepted_length, output blocked,
                    output read_byte_out, output byte_valid, output last_of_record,
                    output wake_writer, input ready);
    modport sink   (input valid, input accepted_length, input blocked,
                    input read_byte_out, input byte_valid, input last_of_record,
                    input wake_writer, output ready);
endinterface

interface rrw_cfg_if;
    logic          valid;
    logic          ready;
    rrw_pkg::len_t ring_bytes_in_use;

    modport source (output valid, output ring_bytes_in_use, input ready);
    modport sink   (input valid, input ring_bytes_in_use, output ready);
endinterface

>>> rtl/core/rrw_ram.sv
// Generic simple dual-port RAM with registered read.
module rrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/rrw_core.sv
// Record ring sequencer: header and data memories, read-modify-write per request.
module rrw_core (
    input  logic          clk,
    input  logic          rst_n,
    input  rrw_pkg::len_t ring_size,
    input  logic          cfg_wr,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rrw_pkg::cmd_t cmd_data,
    output logic          res_valid,
    input  logic          res_ready,
    output rrw_pkg::res_t res_data
);

    rrw_pkg::state_t state_reg, state_next;
    rrw_pkg::slot_t  clr_cnt_reg, clr_cnt_next;

    rrw_pkg::off_t wr_off_reg, wr_off_next;
    rrw_pkg::off_t rd_off_reg, rd_off_next;
    rrw_pkg::off_t wr_cur_reg, wr_cur_next;
    rrw_pkg::off_t rd_cur_reg, rd_cur_next;
    rrw_pkg::off_t nxt_off_reg, nxt_off_next;
    rrw_pkg::len_t wr_rem_reg, wr_rem_next;
    rrw_pkg::len_t pend_reg, pend_next;
    rrw_pkg::len_t rd_rem_reg, rd_rem_next;
    rrw_pkg::len_t rd_len_reg, rd_len_next;
    logic          blocked_reg, blocked_next;

    // request payload captured at accept
    logic [rrw_pkg::OP_W-1:0] op_reg;
    rrw_pkg::byte_t           byte_reg;
    rrw_pkg::len_t            req_reg;
    rrw_pkg::len_t            free_reg;
    rrw_pkg::off_t            rd_addr_reg;

    logic clr_active;
    logic cmd_fire;
    logic exec_go;

    // memory ports
    logic           hdr_we;
    rrw_pkg::slot_t hdr_waddr;
    rrw_pkg::len_t  hdr_wdata;
    rrw_pkg::len_t  hdr_rdata;
    logic           dat_we;
    rrw_pkg::byte_t dat_rdata;

    // accept-cycle values
    rrw_pkg::len_t free_calc;
    rrw_pkg::off_t rd_addr_calc;

    // execute-cycle values
    logic          beg_skip, beg_block;
    rrw_pkg::len_t avail, beg_len;
    rrw_pkg::off_t beg_next, beg_cur;
    logic          rd_start, rd_empty, rd_last;
    rrw_pkg::len_t rd_len_eff, rd_rem_eff;
    rrw_pkg::off_t rd_next_off, rd_cur_inc, wr_cur_inc;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign exec_go  = res_valid && res_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrw_pkg::ST_CLEAR:
                if (clr_cnt_reg == rrw_pkg::slot_t'(rrw_pkg::HDR_SLOTS - 1))
                    state_next = rrw_pkg::ST_IDLE;
            rrw_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = rrw_pkg::ST_EXEC;
            rrw_pkg::ST_EXEC:
                if (res_ready)
                    state_next = rrw_pkg::ST_IDLE;
            default:
                state_next = rrw_pkg::ST_CLEAR;
        endcase
        if (cfg_wr)
            state_next = rrw_pkg::ST_CLEAR;
    end

    // FSM outputs
    always_comb
    begin
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        clr_active = 1'b0;
        case (state_reg)
            rrw_pkg::ST_CLEAR: clr_active = 1'b1;
            rrw_pkg::ST_IDLE:  cmd_ready  = 1'b1;
            rrw_pkg::ST_EXEC:  res_valid  = 1'b1;
            default:           clr_active = 1'b0;
        endcase
    end

    assign clr_cnt_next = clr_active ? clr_cnt_reg + rrw_pkg::slot_t'(1) : '0;

    // free space and read address, taken at accept
    assign free_calc = (wr_off_reg >= rd_off_reg)
                     ? ring_size - rrw_pkg::LEN_W'(wr_off_reg - rd_off_reg)
                     : rrw_pkg::LEN_W'(rd_off_reg - wr_off_reg);
    assign rd_addr_calc = (rd_rem_reg == '0)
                        ? rrw_pkg::wrap_off(rrw_pkg::SUM_W'(rd_off_reg)
                                            + rrw_pkg::SUM_W'(rrw_pkg::HDR_BYTES), ring_size)
                        : rd_cur_reg;

    // begin_record arithmetic
    assign beg_skip  = (req_reg == '0) || (wr_rem_reg != '0);
    assign beg_block = free_reg <= rrw_pkg::LEN_W'(rrw_pkg::MARGIN);
    assign avail     = free_reg - rrw_pkg::LEN_W'(rrw_pkg::MARGIN);
    assign beg_len   = (req_reg > avail) ? avail : req_reg;
    assign beg_next  = rrw_pkg::wrap_off(
                           rrw_pkg::round_hdr(rrw_pkg::SUM_W'(wr_off_reg)
                                              + rrw_pkg::SUM_W'(rrw_pkg::HDR_BYTES)
                                              + rrw_pkg::SUM_W'(beg_len)),
                           ring_size);
    assign beg_cur   = rrw_pkg::wrap_off(rrw_pkg::SUM_W'(wr_off_reg)
                                         + rrw_pkg::SUM_W'(rrw_pkg::HDR_BYTES), ring_size);

    // read_byte arithmetic; header only matters when a new record starts
    assign rd_start    = rd_rem_reg == '0;
    assign rd_len_eff  = rd_start ? hdr_rdata : rd_len_reg;
    assign rd_rem_eff  = rd_start ? hdr_rdata : rd_rem_reg;
    assign rd_empty    = rd_start && (hdr_rdata == '0);
    assign rd_last     = rd_rem_eff == rrw_pkg::len_t'(1);
    assign rd_next_off = rrw_pkg::wrap_off(
                             rrw_pkg::round_hdr(rrw_pkg::SUM_W'(rd_off_reg)
                                                + rrw_pkg::SUM_W'(rrw_pkg::HDR_BYTES)
                                                + rrw_pkg::SUM_W'(rd_len_eff)),
                             ring_size);
    assign rd_cur_inc  = rrw_pkg::wrap_off(rrw_pkg::SUM_W'(rd_addr_reg)
                                           + rrw_pkg::SUM_W'(1), ring_size);
    assign wr_cur_inc  = rrw_pkg::wrap_off(rrw_pkg::SUM_W'(wr_cur_reg)
                                           + rrw_pkg::SUM_W'(1), ring_size);

    // execute: result, memory writes and register updates
    always_comb
    begin
        wr_off_next  = wr_off_reg;
        rd_off_next  = rd_off_reg;
        wr_cur_next  = wr_cur_reg;
        rd_cur_next  = rd_cur_reg;
        nxt_off_next = nxt_off_reg;
        wr_rem_next  = wr_rem_reg;
        pend_next    = pend_reg;
        rd_rem_next  = rd_rem_reg;
        rd_len_next  = rd_len_reg;
        blocked_next = blocked_reg;
        hdr_we       = clr_active;
        hdr_waddr    = clr_cnt_reg;
        hdr_wdata    = '0;
        dat_we       = 1'b0;
        res_data     = '0;
        if (state_reg == rrw_pkg::ST_EXEC)
        begin
            case (op_reg)
                rrw_pkg::OP_BEGIN:
                begin
                    if (!beg_skip && beg_block)
                    begin
                        blocked_next     = 1'b1;
                        res_data.blocked = 1'b1;
                    end
                    else if (!beg_skip)
                    begin
                        // clear the header slot after the new record
                        res_data.accepted_length = beg_len;
                        hdr_we       = exec_go;
                        hdr_waddr    = rrw_pkg::slot_of(beg_next);
                        wr_cur_next  = beg_cur;
                        wr_rem_next  = beg_len;
                        pend_next    = beg_len;
                        nxt_off_next = beg_next;
                    end
                end
                rrw_pkg::OP_WRITE:
                begin
                    if (wr_rem_reg != '0)
                    begin
                        dat_we      = exec_go;
                        wr_cur_next = wr_cur_inc;
                        wr_rem_next = wr_rem_reg - rrw_pkg::len_t'(1);
                        if (wr_rem_reg == rrw_pkg::len_t'(1))
                        begin
                            // last byte commits the header
                            hdr_we      = exec_go;
                            hdr_waddr   = rrw_pkg::slot_of(wr_off_reg);
                            hdr_wdata   = pend_reg;
                            wr_off_next = nxt_off_reg;
                        end
                    end
                end
                rrw_pkg::OP_READ:
                begin
                    if (!rd_empty)
                    begin
                        res_data.read_byte_out = dat_rdata;
                        res_data.byte_valid    = 1'b1;
                        rd_cur_next = rd_cur_inc;
                        rd_rem_next = rd_rem_eff - rrw_pkg::len_t'(1);
                        rd_len_next = rd_len_eff;
                        if (rd_last)
                        begin
                            res_data.last_of_record = 1'b1;
                            res_data.wake_writer    = blocked_reg;
                            blocked_next = 1'b0;
                            rd_off_next  = rd_next_off;
                            hdr_we       = exec_go;
                            hdr_waddr    = rrw_pkg::slot_of(rd_off_reg);
                        end
                    end
                end
                default:
                begin
                    res_data = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rrw_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            wr_off_reg  <= '0;
            rd_off_reg  <= '0;
            wr_cur_reg  <= '0;
            rd_cur_reg  <= '0;
            nxt_off_reg <= '0;
            wr_rem_reg  <= '0;
            pend_reg    <= '0;
            rd_rem_reg  <= '0;
            rd_len_reg  <= '0;
            blocked_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= cfg_wr ? '0 : clr_cnt_next;
            if (cfg_wr)
            begin
                wr_off_reg  <= '0;
                rd_off_reg  <= '0;
                wr_cur_reg  <= '0;
                rd_cur_reg  <= '0;
                nxt_off_reg <= '0;
                wr_rem_reg  <= '0;
                pend_reg    <= '0;
                rd_rem_reg  <= '0;
                rd_len_reg  <= '0;
                blocked_reg <= 1'b0;
            end
            else if (exec_go)
            begin
                wr_off_reg  <= wr_off_next;
                rd_off_reg  <= rd_off_next;
                wr_cur_reg  <= wr_cur_next;
                rd_cur_reg  <= rd_cur_next;
                nxt_off_reg <= nxt_off_next;
                wr_rem_reg  <= wr_rem_next;
                pend_reg    <= pend_next;
                rd_rem_reg  <= rd_rem_next;
                rd_len_reg  <= rd_len_next;
                blocked_reg <= blocked_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg      <= cmd_data.opcode;
            byte_reg    <= cmd_data.data_byte;
            req_reg     <= cmd_data.request_length;
            free_reg    <= free_calc;
            rd_addr_reg <= rd_addr_calc;
        end
    end

    rrw_ram #(
        .WIDTH (rrw_pkg::LEN_W),
        .DEPTH (rrw_pkg::HDR_SLOTS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .re    (cmd_fire),
        .raddr (rrw_pkg::slot_of(rd_off_reg)),
        .rdata (hdr_rdata)
    );

    rrw_ram #(
        .WIDTH (rrw_pkg::BYTE_W),
        .DEPTH (rrw_pkg::RING_BYTES)
    ) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (wr_cur_reg),
        .wdata (byte_reg),
        .re    (cmd_fire),
        .raddr (rd_addr_calc),
        .rdata (dat_rdata)
    );

endmodule

>>> rtl/core/record_ring_writer_reader.sv
// Top level of the variable-length record ring: config register, sequencer, result register.
// Requests pass one at a time through one shared sequencer: no new request is taken until
//   the last one's execute state ends, which stalls while the result register is full.
//   Header and data memories are read at accept; their writes and the result come as it ends.
// Reset: rst_n clears all control state and starts a pass zeroing all 2048 header slots;
//   cmd.ready stays low during it. Each cfg write restarts that same pass.
module record_ring_writer_reader (
    input  logic      clk,
    input  logic      rst_n,
    rrw_cmd_if.sink   cmd,
    rrw_rsp_if.source rsp,
    rrw_cfg_if.sink   cfg
);

    // active ring size, already clamped and rounded to a header multiple
    rrw_pkg::len_t size_reg;
    logic          cfg_wr;

    rrw_pkg::cmd_t cmd_data;
    rrw_pkg::res_t res_data;
    logic          res_valid;
    logic          res_ready;

    // result register: parts the sequencer from the downstream handshake
    logic          rsp_valid_reg;
    rrw_pkg::res_t rsp_data_reg;

    // config is always taken; writes are only legal when the block is idle
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rrw_pkg::LEN_W'(rrw_pkg::RING_BYTES);
        end
        else if (cfg_wr)
        begin
            size_reg <= rrw_pkg::ring_size_of(cfg.ring_bytes_in_use);
        end
    end

    assign cmd_data.opcode         = cmd.opcode;
    assign cmd_data.data_byte      = cmd.data_byte;
    assign cmd_data.request_length = cmd.request_length;

    rrw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_size (size_reg),
        .cfg_wr    (cfg_wr),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // sequencer may finish when the register is empty or being drained
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.accepted_length = rsp_data_reg.accepted_length;
    assign rsp.blocked         = rsp_data_reg.blocked;
    assign rsp.read_byte_out   = rsp_data_reg.read_byte_out;
    assign rsp.byte_valid      = rsp_data_reg.byte_valid;
    assign rsp.last_of_record  = rsp_data_reg.last_of_record;
    assign rsp.wake_writer     = rsp_data_reg.wake_writer;

endmodule

>>> rtl/core/rrw_checker.sv
// Port-level assertions for the record ring, bound to the top level.
module rrw_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input rrw_pkg::len_t  accepted_length,
    input logic           blocked,
    input rrw_pkg::byte_t read_byte_out,
    input logic           byte_valid,
    input logic           last_of_record,
    input logic           wake_writer,
    input logic           cfg_valid,
    input logic           cfg_ready
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted_length)
            && $stable(blocked) && $stable(read_byte_out) && $stable(byte_valid)
            && $stable(last_of_record) && $stable(wake_writer))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while another is in flight");

    // a config write starts the header clear pass
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cmd_ready)
        else $error("request taken right after config write");

    // a blocked begin accepts nothing and returns no byte
    a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && blocked |-> accepted_length == '0 && !byte_valid)
        else $error("blocked result carries data");

    // end-of-record and wake come only with a returned byte, wake only at the end
    a_last_wake: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (last_of_record || wake_writer) |-> byte_valid
            && (last_of_record || !wake_writer))
        else $error("record end flags without a byte");

endmodule

bind record_ring_writer_reader rrw_checker u_rrw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .accepted_length (rsp.accepted_length),
    .blocked         (rsp.blocked),
    .read_byte_out   (rsp.read_byte_out),
    .byte_valid      (rsp.byte_valid),
    .last_of_record  (rsp.last_of_record),
    .wake_writer     (rsp.wake_writer),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready)
);
